/* rtl/i2c_transaction_sequencer_assert.svh */
// Assertion macros shared by the sequencer RTL.
`ifndef I2C_TRANSACTION_SEQUENCER_ASSERT_SVH
`define I2C_TRANSACTION_SEQUENCER_ASSERT_SVH

// Clocked implication check, disabled while reset is held.
`define I2CTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, active during reset too.
`define I2CTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/i2cts_pkg.sv */
package i2cts_pkg;

    // Bus primitive codes.
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_WRITE = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_ACK   = 3'd3;
    localparam logic [2:0] OP_NAK   = 3'd4;
    localparam logic [2:0] OP_STOP  = 3'd5;

    // Stop status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BUS_ERR = 2'd1;
    localparam logic [1:0] ST_MISCMP  = 2'd2;

    // Sequencer phases.
    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_START1 = 4'd1;
    localparam logic [3:0] PH_ADDR1  = 4'd2;
    localparam logic [3:0] PH_SUBHI  = 4'd3;
    localparam logic [3:0] PH_SUBLO  = 4'd4;
    localparam logic [3:0] PH_RSTART = 4'd5;
    localparam logic [3:0] PH_ADDR2  = 4'd6;
    localparam logic [3:0] PH_READ   = 4'd7;
    localparam logic [3:0] PH_ACKNAK = 4'd8;
    localparam logic [3:0] PH_WRITE  = 4'd9;
    localparam logic [3:0] PH_CMPNAK = 4'd10;

    // Bit positions in the latched flag vector.
    localparam int FL_RD  = 0;
    localparam int FL_WR  = 1;
    localparam int FL_SUB = 2;
    localparam int FL_LNG = 3;
    localparam int FL_CP  = 4;

    // Input item command codes.
    localparam logic CMD_BEGIN = 1'b0;

    typedef struct packed {
        logic [3:0]  phase;
        logic [4:0]  flags;
        logic [6:0]  address;
        logic [15:0] subaddress;
        logic [15:0] remaining;
        logic [15:0] done_count;
    } t_seq_state;

    typedef struct packed {
        logic        command;
        logic [6:0]  device_address;
        logic        do_read;
        logic        do_write;
        logic        use_subaddress;
        logic        long_subaddress;
        logic        compare_only;
        logic [15:0] subaddress;
        logic [15:0] byte_count;
        logic [7:0]  block_byte;
        logic [3:0]  prim_status;
        logic [7:0]  read_data;
    } t_item;

    typedef struct packed {
        logic [2:0]  bus_op;
        logic [7:0]  bus_byte;
        logic        store_valid;
        logic [7:0]  store_byte;
        logic [15:0] bytes_done;
        logic [1:0]  status;
        logic [3:0]  error_code;
    } t_result;

endpackage

/* rtl/i2cts_step.sv */
module i2cts_step (
    input  i2cts_pkg::t_seq_state i_state,
    input  i2cts_pkg::t_item      i_item,
    output i2cts_pkg::t_seq_state o_next,
    output i2cts_pkg::t_result    o_result,
    output logic                  o_has_result
);
    import i2cts_pkg::*;

    always_comb begin
        logic [4:0] f;
        logic       go_data;
        logic       fin;
        logic [1:0] fin_status;
        logic [3:0] fin_code;

        o_next       = i_state;
        o_result     = '0;
        o_has_result = 1'b0;
        f            = '0;
        go_data      = 1'b0;
        fin          = 1'b0;
        fin_status   = ST_OK;
        fin_code     = 4'd0;

        if (i_item.command == CMD_BEGIN) begin
            f[FL_RD]  = i_item.do_read;
            f[FL_WR]  = i_item.do_write;
            f[FL_SUB] = i_item.use_subaddress;
            f[FL_LNG] = i_item.long_subaddress;
            f[FL_CP]  = i_item.compare_only;
            // A zero count turns the request into an address poll.
            if (i_item.byte_count == 16'd0) begin
                f[FL_RD] = 1'b0;
                f[FL_WR] = 1'b0;
            end
            o_next.flags      = f;
            o_next.address    = i_item.device_address;
            o_next.subaddress = i_item.subaddress;
            o_next.remaining  = i_item.byte_count;
            o_next.done_count = 16'd0;
            o_next.phase      = PH_START1;
            o_result.bus_op   = OP_START;
            o_has_result      = 1'b1;
        end else if (i_state.phase == PH_IDLE || i_state.phase > PH_CMPNAK) begin
            o_has_result = 1'b0;
        end else if (i_state.phase == PH_CMPNAK) begin
            o_has_result = 1'b1;
            fin          = 1'b1;
            fin_status   = ST_MISCMP;
        end else if (i_item.prim_status != 4'd0) begin
            o_has_result = 1'b1;
            fin          = 1'b1;
            fin_status   = ST_BUS_ERR;
            fin_code     = i_item.prim_status;
        end else begin
            o_has_result = 1'b1;
            case (i_state.phase)
                PH_START1: begin
                    o_next.phase      = PH_ADDR1;
                    o_result.bus_op   = OP_WRITE;
                    o_result.bus_byte = {i_state.address,
                                         i_state.flags[FL_RD] & ~i_state.flags[FL_SUB]};
                end
                PH_ADDR1: begin
                    if (!i_state.flags[FL_RD] && !i_state.flags[FL_WR]) begin
                        fin = 1'b1;
                    end else if (i_state.flags[FL_SUB]) begin
                        o_result.bus_op = OP_WRITE;
                        if (i_state.flags[FL_LNG]) begin
                            o_next.phase      = PH_SUBHI;
                            o_result.bus_byte = i_state.subaddress[15:8];
                        end else begin
                            o_next.phase      = PH_SUBLO;
                            o_result.bus_byte = i_state.subaddress[7:0];
                        end
                    end else begin
                        go_data = 1'b1;
                    end
                end
                PH_SUBHI: begin
                    o_next.phase      = PH_SUBLO;
                    o_result.bus_op   = OP_WRITE;
                    o_result.bus_byte = i_state.subaddress[7:0];
                end
                PH_SUBLO: begin
                    if (i_state.flags[FL_RD]) begin
                        o_next.phase    = PH_RSTART;
                        o_result.bus_op = OP_START;
                    end else begin
                        go_data = 1'b1;
                    end
                end
                PH_RSTART: begin
                    o_next.phase      = PH_ADDR2;
                    o_result.bus_op   = OP_WRITE;
                    o_result.bus_byte = {i_state.address, 1'b1};
                end
                PH_ADDR2: begin
                    go_data = 1'b1;
                end
                PH_READ: begin
                    if (i_state.flags[FL_CP] && i_item.block_byte != i_item.read_data) begin
                        o_next.phase    = PH_CMPNAK;
                        o_result.bus_op = OP_NAK;
                    end else begin
                        if (i_state.remaining != 16'd0) begin
                            o_next.remaining = i_state.remaining - 16'd1;
                        end
                        o_next.phase    = PH_ACKNAK;
                        o_result.bus_op = (o_next.remaining != 16'd0) ? OP_ACK : OP_NAK;
                        if (!i_state.flags[FL_CP]) begin
                            o_result.store_valid = 1'b1;
                            o_result.store_byte  = i_item.read_data;
                        end
                    end
                end
                PH_ACKNAK: begin
                    o_next.done_count = i_state.done_count + 16'd1;
                    go_data           = 1'b1;
                end
                PH_WRITE: begin
                    o_next.done_count = i_state.done_count + 16'd1;
                    if (i_state.remaining != 16'd0) begin
                        o_next.remaining = i_state.remaining - 16'd1;
                    end
                    go_data = 1'b1;
                end
                default: begin
                    o_has_result = 1'b0;
                end
            endcase
        end

        // Data phase: finish when no bytes are left, else read or write one.
        if (go_data) begin
            if (o_next.remaining == 16'd0) begin
                fin = 1'b1;
            end else if (i_state.flags[FL_RD]) begin
                o_next.phase    = PH_READ;
                o_result.bus_op = OP_READ;
            end else begin
                o_next.phase      = PH_WRITE;
                o_result.bus_op   = OP_WRITE;
                o_result.bus_byte = i_item.block_byte;
            end
        end

        if (fin) begin
            o_next.phase        = PH_IDLE;
            o_result            = '0;
            o_result.bus_op     = OP_STOP;
            o_result.status     = fin_status;
            o_result.error_code = fin_code;
        end

        o_result.bytes_done = o_next.done_count;
    end

endmodule

/* rtl/i2c_transaction_sequencer.sv */
// A result is registered and presented in the cycle after the transfer that caused it.
// Throughput: one input transfer per cycle, limited only by the single output register.
// A completion that arrives while idle is absorbed and produces no result.
// Reset (i_rst_n low, synchronous) returns the sequencer to idle with all
// latched transaction fields cleared and the output register empty.
module i2c_transaction_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata, low bit up: device_address[6:0], do_read, do_write, use_subaddress,
    // long_subaddress, compare_only, subaddress[15:0], byte_count[15:0],
    // block_byte[7:0], prim_status[3:0], read_data[7:0]
    input  logic [63:0] i_s_tdata,
    // tuser: command (0 begin transaction, 1 previous primitive completed)
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata, low bit up: bus_byte[7:0], store_valid, store_byte[7:0],
    // bytes_done[15:0], status[1:0], error_code[3:0], zero pad
    output logic [39:0] o_m_tdata,
    // tuser: bus_op[2:0]
    output logic [2:0]  o_m_tuser
);
    import i2cts_pkg::*;

    // The whole transaction context lives in this one register set. Every
    // transfer is decoded against it in a single combinational pass.
    t_seq_state r_state;
    t_seq_state n_state;

    // Output register: holds one result until the downstream side takes it.
    logic    r_out_valid;
    t_result r_out;

    t_item   w_item;
    t_result w_result;
    logic    w_has_result;
    logic    w_accept;
    logic    w_load;

    assign w_item.command         = i_s_tuser;
    assign w_item.device_address  = i_s_tdata[6:0];
    assign w_item.do_read         = i_s_tdata[7];
    assign w_item.do_write        = i_s_tdata[8];
    assign w_item.use_subaddress  = i_s_tdata[9];
    assign w_item.long_subaddress = i_s_tdata[10];
    assign w_item.compare_only    = i_s_tdata[11];
    assign w_item.subaddress      = i_s_tdata[27:12];
    assign w_item.byte_count      = i_s_tdata[43:28];
    assign w_item.block_byte      = i_s_tdata[51:44];
    assign w_item.prim_status     = i_s_tdata[55:52];
    assign w_item.read_data       = i_s_tdata[63:56];

    i2cts_step u_step (
        .i_state      (r_state),
        .i_item       (w_item),
        .o_next       (n_state),
        .o_result     (w_result),
        .o_has_result (w_has_result)
    );

    // A new transfer is taken whenever the output register is empty or is
    // being emptied in this same cycle, so back-to-back transfers stream.
    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_load     = w_accept && w_has_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.bus_op;
    assign o_m_tdata  = {1'b0, r_out.error_code, r_out.status, r_out.bytes_done,
                         r_out.store_byte, r_out.store_valid, r_out.bus_byte};

`include "i2c_transaction_sequencer_assert.svh"

    // A stop always leaves the sequencer idle.
    `I2CTS_ASSERT(a_stop_idles, i_clk, i_rst_n,
        (w_load && w_result.bus_op == OP_STOP) |=> (r_state.phase == PH_IDLE),
        "stop result did not return sequencer to idle")
    // A begin transfer restarts the transaction with no bytes done.
    `I2CTS_ASSERT(a_begin_restart, i_clk, i_rst_n,
        (w_accept && i_s_tuser == CMD_BEGIN) |=> (r_state.phase == PH_START1 &&
            r_state.done_count == 16'd0 && r_out_valid && r_out.bus_op == OP_START),
        "begin transfer did not restart the transaction")
    // Status and error code only ever travel with a stop.
    `I2CTS_ASSERT(a_status_on_stop, i_clk, i_rst_n,
        (r_out_valid && r_out.status != ST_OK) |-> (r_out.bus_op == OP_STOP),
        "nonzero status on a primitive other than stop")
    `I2CTS_ASSERT(a_code_bus_err, i_clk, i_rst_n,
        (r_out_valid && r_out.error_code != 4'd0) |-> (r_out.status == ST_BUS_ERR),
        "error code without bus error status")
    // A stored byte only accompanies the ack or nak of a read byte.
    `I2CTS_ASSERT(a_store_acknak, i_clk, i_rst_n,
        (r_out_valid && r_out.store_valid) |-> ((r_out.bus_op == OP_ACK ||
            r_out.bus_op == OP_NAK) && r_state.phase == PH_ACKNAK),
        "store without read ack or nak")
    // The output register is empty right after reset.
    `I2CTS_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid,
        "output valid after reset")

endmodule

/* tb/i2c_transaction_sequencer_tb.sv */
`timescale 1ns / 1ps

module i2c_transaction_sequencer_tb;
    import i2cts_pkg::*;

    // A completion item carries the opposite command code of a begin item.
    localparam logic CMD_DONE = ~CMD_BEGIN;

    // The run ends as a failure once this many cycles pass with no transfer
    // on either side.
    localparam int WATCHDOG_LIMIT = 5000;

    // Number of primitive results that the random part of the stimulus aims for.
    localparam int RANDOM_RESULTS = 1200;

    // Cycles to linger after the last expected primitive has arrived.
    localparam int DRAIN_CYCLES = 20;

    // In-order prediction of the primitive sequence, together with the
    // store of primitives still owed by the block and the mismatch bookkeeping.
    class sequencer_model;
        logic [3:0]  phase;
        logic [4:0]  flags;
        logic [6:0]  address;
        logic [15:0] subaddr;
        logic [15:0] remaining;
        logic [15:0] done_count;
        t_result     pending_prims[$];
        int          mismatches;
        int          prims_predicted;
        int          prims_checked;
        int          transactions;
        int          stored_bytes;
        int          stops[3];

        function new();
            phase           = PH_IDLE;
            flags           = '0;
            address         = '0;
            subaddr         = '0;
            remaining       = '0;
            done_count      = '0;
            mismatches      = 0;
            prims_predicted = 0;
            prims_checked   = 0;
            transactions    = 0;
            stored_bytes    = 0;
            stops           = '{0, 0, 0};
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= 40)
                $display("MISMATCH at %0t ns: %s", $time, msg);
        endtask

        function void issue(logic [2:0] op, logic [7:0] wbyte, logic keep,
                            logic [7:0] kept_byte, logic [1:0] st, logic [3:0] ec);
            t_result r;
            r.bus_op      = op;
            r.bus_byte    = wbyte;
            r.store_valid = keep;
            r.store_byte  = kept_byte;
            r.bytes_done  = done_count;
            r.status      = st;
            r.error_code  = ec;
            pending_prims.push_back(r);
            prims_predicted++;
        endfunction

        function void issue_stop(logic [1:0] st, logic [3:0] ec);
            phase = PH_IDLE;
            stops[st]++;
            issue(OP_STOP, 8'h00, 1'b0, 8'h00, st, ec);
        endfunction

        // Either the next block byte, or the final stop when nothing is left.
        function void next_data_prim(logic [7:0] blk);
            if (remaining == 16'd0) begin
                issue_stop(ST_OK, 4'd0);
            end else if (flags[FL_RD]) begin
                phase = PH_READ;
                issue(OP_READ, 8'h00, 1'b0, 8'h00, ST_OK, 4'd0);
            end else begin
                phase = PH_WRITE;
                issue(OP_WRITE, blk, 1'b0, 8'h00, ST_OK, 4'd0);
            end
        endfunction

        // Advances the prediction by one accepted input item.
        function void note_item(t_item it);
            logic [4:0] f;
            logic       keep;
            if (it.command == CMD_BEGIN) begin
                f = {it.compare_only, it.long_subaddress, it.use_subaddress,
                     it.do_write, it.do_read};
                remaining = it.byte_count;
                if (remaining == 16'd0) begin
                    f[FL_RD] = 1'b0;
                    f[FL_WR] = 1'b0;
                end
                flags      = f;
                address    = it.device_address;
                subaddr    = it.subaddress;
                done_count = '0;
                phase      = PH_START1;
                transactions++;
                issue(OP_START, 8'h00, 1'b0, 8'h00, ST_OK, 4'd0);
            end else if (phase == PH_IDLE || phase > PH_CMPNAK) begin
                // A completion with no transaction running is dropped.
            end else if (phase == PH_CMPNAK) begin
                // The outcome of the miscompare NAK does not matter.
                issue_stop(ST_MISCMP, 4'd0);
            end else if (it.prim_status != 4'd0) begin
                issue_stop(ST_BUS_ERR, it.prim_status);
            end else begin
                case (phase)
                    PH_START1: begin
                        phase = PH_ADDR1;
                        issue(OP_WRITE, {address, flags[FL_RD] & ~flags[FL_SUB]},
                              1'b0, 8'h00, ST_OK, 4'd0);
                    end
                    PH_ADDR1: begin
                        if (!flags[FL_RD] && !flags[FL_WR]) begin
                            issue_stop(ST_OK, 4'd0);
                        end else if (flags[FL_SUB] && flags[FL_LNG]) begin
                            phase = PH_SUBHI;
                            issue(OP_WRITE, subaddr[15:8], 1'b0, 8'h00, ST_OK, 4'd0);
                        end else if (flags[FL_SUB]) begin
                            phase = PH_SUBLO;
                            issue(OP_WRITE, subaddr[7:0], 1'b0, 8'h00, ST_OK, 4'd0);
                        end else begin
                            next_data_prim(it.block_byte);
                        end
                    end
                    PH_SUBHI: begin
                        phase = PH_SUBLO;
                        issue(OP_WRITE, subaddr[7:0], 1'b0, 8'h00, ST_OK, 4'd0);
                    end
                    PH_SUBLO: begin
                        if (flags[FL_RD]) begin
                            phase = PH_RSTART;
                            issue(OP_START, 8'h00, 1'b0, 8'h00, ST_OK, 4'd0);
                        end else begin
                            next_data_prim(it.block_byte);
                        end
                    end
                    PH_RSTART: begin
                        phase = PH_ADDR2;
                        issue(OP_WRITE, {address, 1'b1}, 1'b0, 8'h00, ST_OK, 4'd0);
                    end
                    PH_ADDR2: next_data_prim(it.block_byte);
                    PH_READ: begin
                        if (flags[FL_CP] && it.block_byte != it.read_data) begin
                            phase = PH_CMPNAK;
                            issue(OP_NAK, 8'h00, 1'b0, 8'h00, ST_OK, 4'd0);
                        end else begin
                            keep = ~flags[FL_CP];
                            if (remaining != 16'd0)
                                remaining = remaining - 16'd1;
                            if (keep)
                                stored_bytes++;
                            phase = PH_ACKNAK;
                            issue((remaining != 16'd0) ? OP_ACK : OP_NAK, 8'h00, keep,
                                  keep ? it.read_data : 8'h00, ST_OK, 4'd0);
                        end
                    end
                    PH_ACKNAK: begin
                        done_count = done_count + 16'd1;
                        next_data_prim(it.block_byte);
                    end
                    PH_WRITE: begin
                        done_count = done_count + 16'd1;
                        if (remaining != 16'd0)
                            remaining = remaining - 16'd1;
                        next_data_prim(it.block_byte);
                    end
                    default: begin
                    end
                endcase
            end
        endfunction

        task compare_field(string name, int unsigned got, int unsigned want, int idx);
            if (got != want)
                report($sformatf("primitive %0d: %s is 0x%0h, expected 0x%0h",
                                 idx, name, got, want));
        endtask

        // Compares one transfer from the block with the oldest owed primitive.
        task check_prim(t_result got);
            t_result want;
            if (pending_prims.size() == 0) begin
                report($sformatf("unexpected primitive op %0d byte 0x%0h",
                                 got.bus_op, got.bus_byte));
            end else begin
                want = pending_prims.pop_front();
                compare_field("bus_op", 32'(got.bus_op), 32'(want.bus_op),
                              prims_checked);
                compare_field("bus_byte", 32'(got.bus_byte), 32'(want.bus_byte),
                              prims_checked);
                compare_field("store_valid", 32'(got.store_valid),
                              32'(want.store_valid), prims_checked);
                compare_field("store_byte", 32'(got.store_byte),
                              32'(want.store_byte), prims_checked);
                compare_field("bytes_done", 32'(got.bytes_done),
                              32'(want.bytes_done), prims_checked);
                compare_field("status", 32'(got.status), 32'(want.status),
                              prims_checked);
                compare_field("error_code", 32'(got.error_code),
                              32'(want.error_code), prims_checked);
            end
            prims_checked++;
        endtask
    endclass

    logic        i_clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [2:0]  m_tuser;

    sequencer_model model = new();

    int burst_left  = 0;
    int idle_cycles = 0;
    int rx_cycle    = 0;

    i2c_transaction_sequencer dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    // 8 ns clock period.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // The receiver moves in turn through four stall patterns: always ready,
    // mostly ready, mostly stalled, and a fixed short cycle.
    always @(negedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        case (rx_cycle[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= ((rx_cycle % 5) < 2);
        endcase
    end

    // Packs an input item into the slave tdata layout, device address at the bottom.
    function automatic logic [63:0] pack_item(t_item it);
        return {it.read_data, it.prim_status, it.block_byte, it.byte_count,
                it.subaddress, it.compare_only, it.long_subaddress,
                it.use_subaddress, it.do_write, it.do_read, it.device_address};
    endfunction

    // Rebuilds the item that the block saw from the bus, so the prediction
    // works from exactly what was transferred.
    function automatic t_item unpack_item(logic [63:0] d, logic cmd);
        t_item it;
        it.command         = cmd;
        it.device_address  = d[6:0];
        it.do_read         = d[7];
        it.do_write        = d[8];
        it.use_subaddress  = d[9];
        it.long_subaddress = d[10];
        it.compare_only    = d[11];
        it.subaddress      = d[27:12];
        it.byte_count      = d[43:28];
        it.block_byte      = d[51:44];
        it.prim_status     = d[55:52];
        it.read_data       = d[63:56];
        return it;
    endfunction

    function automatic t_result unpack_prim(logic [39:0] d, logic [2:0] op);
        t_result r;
        r.bus_op      = op;
        r.bus_byte    = d[7:0];
        r.store_valid = d[8];
        r.store_byte  = d[16:9];
        r.bytes_done  = d[32:17];
        r.status      = d[34:33];
        r.error_code  = d[38:35];
        return r;
    endfunction

    function automatic t_item begin_item(logic [6:0] addr, logic rd, logic wr, logic sub,
                                         logic lng, logic cp, logic [15:0] subaddress,
                                         logic [15:0] count);
        t_item it;
        it                 = '0;
        it.command         = CMD_BEGIN;
        it.device_address  = addr;
        it.do_read         = rd;
        it.do_write        = wr;
        it.use_subaddress  = sub;
        it.long_subaddress = lng;
        it.compare_only    = cp;
        it.subaddress      = subaddress;
        it.byte_count      = count;
        return it;
    endfunction

    function automatic t_item done_item(logic [3:0] ps, logic [7:0] blk, logic [7:0] rd);
        t_item it;
        it             = '0;
        it.command     = CMD_DONE;
        it.prim_status = ps;
        it.block_byte  = blk;
        it.read_data   = rd;
        return it;
    endfunction

    // Builds the next random item. The generator plays the part of the bus
    // engine: while a transaction runs it mostly reports clean completions, and
    // reads that are compared usually match. Aborts, bus errors, miscompares and
    // stray completions while idle are mixed in at low rates.
    function automatic t_item next_random_item();
        t_item it;
        int    pick;
        it.device_address  = 7'($urandom());
        it.do_read         = 1'($urandom());
        it.do_write        = 1'($urandom());
        it.use_subaddress  = 1'($urandom());
        it.long_subaddress = 1'($urandom());
        it.compare_only    = ($urandom_range(0, 2) == 0);
        it.subaddress      = 16'($urandom());
        it.byte_count      = 16'($urandom());
        it.block_byte      = 8'($urandom());
        it.prim_status     = 4'($urandom());
        it.read_data       = 8'($urandom());
        if (model.phase == PH_IDLE)
            it.command = ($urandom_range(0, 9) == 0) ? CMD_DONE : CMD_BEGIN;
        else
            it.command = ($urandom_range(0, 24) == 0) ? CMD_BEGIN : CMD_DONE;
        if (it.command == CMD_BEGIN) begin
            // Mostly short transactions; a full-range count appears now and then
            // and is cut short by an error or a new begin.
            pick = $urandom_range(0, 99);
            if (pick < 10)
                it.byte_count = 16'd0;
            else if (pick < 85)
                it.byte_count = 16'($urandom_range(1, 6));
            else if (pick < 95)
                it.byte_count = 16'($urandom_range(7, 40));
        end else if (model.phase != PH_IDLE) begin
            it.prim_status = ($urandom_range(0, 29) == 0) ? 4'($urandom_range(1, 15))
                                                          : 4'd0;
            if ($urandom_range(0, 7) != 0)
                it.block_byte = it.read_data;
        end
        return it;
    endfunction

    // Offers one item and holds it until the block takes it. Items go out in
    // bursts of random length, with random gaps between the bursts.
    task automatic send(t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_item(it);
        s_tuser  <= it.command;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        burst_left--;
    endtask

    // Transfer monitor and watchdog. Values are read at the rising edge, before
    // the block's registers update, so each transfer is seen exactly as taken.
    always @(posedge i_clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (s_tvalid && s_tready)
                model.note_item(unpack_item(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
                model.check_prim(unpack_prim(m_tdata, m_tuser));
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles, %0d primitives owed",
                         WATCHDOG_LIMIT, model.pending_prims.size());
                $display("TEST FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int random_base;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_BEGIN;
        m_tready = 1'b0;
        repeat (10) @(negedge i_clk);
        rst_n <= 1'b1;

        // A completion right after reset has no transaction to belong to.
        send(done_item(4'hF, 8'hFF, 8'hFF));

        // Zero count with both direction flags set degrades to an address poll.
        send(begin_item(7'h7F, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'h0000, 16'h0000));
        send(done_item(4'h0, 8'h00, 8'h00));
        send(done_item(4'h0, 8'h00, 8'h00));

        // Two-byte read behind a 16-bit subaddress: address with R/W clear,
        // both subaddress bytes, repeated start, address with R/W set, then
        // one ACKed and one NAKed read, both stored.
        send(begin_item(7'h00, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 16'hFFFF, 16'd2));
        repeat (6) send(done_item(4'h0, 8'h00, 8'h00));
        send(done_item(4'h0, 8'h00, 8'hA5));
        send(done_item(4'h0, 8'h00, 8'h00));
        send(done_item(4'h0, 8'h00, 8'h5A));
        send(done_item(4'h0, 8'h00, 8'h00));

        // Compared read at the largest count: the first byte miscompares, so
        // a NAK follows and then a miscompare stop even though the NAK failed.
        send(begin_item(7'h55, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'h0000, 16'hFFFF));
        send(done_item(4'h0, 8'h00, 8'h00));
        send(done_item(4'h0, 8'h00, 8'h00));
        send(done_item(4'h0, 8'h3C, 8'hC3));
        send(done_item(4'h7, 8'h00, 8'h00));

        // Write behind an 8-bit subaddress that fails on the subaddress byte.
        send(begin_item(7'h2A, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 16'h1234, 16'd3));
        send(done_item(4'h0, 8'h00, 8'h00));
        send(done_item(4'h0, 8'h00, 8'h00));
        send(done_item(4'hF, 8'h00, 8'h00));

        // Random part: run until enough primitives have been predicted; items
        // that the block ignores do not move this count.
        random_base = model.prims_predicted;
        while (model.prims_predicted - random_base < RANDOM_RESULTS)
            send(next_random_item());
        s_tvalid <= 1'b0;

        // Drain everything still owed; the watchdog bounds this wait.
        while (model.pending_prims.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Run covered %0d transactions and %0d checked primitives, %0d bytes stored.",
                 model.transactions, model.prims_checked, model.stored_bytes);
        $display("Stops: %0d success, %0d bus error, %0d miscompare; %0d mismatches.",
                 model.stops[ST_OK], model.stops[ST_BUS_ERR], model.stops[ST_MISCMP],
                 model.mismatches);
        if (model.mismatches == 0 && model.pending_prims.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
